>>> src/text_console_writer_defines.svh
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tcw_pkg.sv
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = 11;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic load;
		logic put;
		logic clear;
		logic read;
		logic fill;
		logic fill_rst;
		logic emit;
	} tcw_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       will_scroll;
		logic       fill_last;
	} tcw_stat_t;

	// Fold a sum of two cell indexes back into the ring of cells.
	function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] s);
		logic [ADDR_W:0] r;
		r = s;
		if (s >= (ADDR_W+1)'(CELL_COUNT)) begin
			r = s - (ADDR_W+1)'(CELL_COUNT);
		end
		return r[ADDR_W-1:0];
	endfunction

endpackage

>>> src/tcw_dpath.sv
// Datapath: screen memory, cursor, row ring offset, sweep counter and result registers.
module tcw_dpath import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_cmd_t          cmd,
	output tcw_stat_t         stat,
	input  logic [1:0]        in_mode,
	input  logic [7:0]        in_char,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	output logic [ADDR_W-1:0] cursor_pos,
	output logic [15:0]       read_data,
	output logic              scrolled
);

	logic [15:0] mem [CELL_COUNT];

	logic [7:0]        attr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] sw_addr_q;
	logic [ADDR_W-1:0] sw_left_q;
	logic              scr_q;

	logic [1:0]        mode_q;
	logic [7:0]        char_q;
	logic [ADDR_W-1:0] addr_q;
	logic [15:0]       rd_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] pos_q;
	logic [15:0]       rdata_q;
	logic              scr_out_q;

	logic              is_cr, is_lf, printable;
	logic              col_last, row_last, row_adv, will_scroll;
	logic [ADDR_W-1:0] lin_cur, put_phys, rd_phys, base_adv;
	logic [15:0]       blank_word;

	// Decode the character and work out the cursor move
	always_comb begin
		is_cr       = (char_q == CH_CR);
		is_lf       = (char_q == CH_LF);
		printable   = !is_cr && !is_lf;
		col_last    = (col_q == COL_W'(COLUMNS - 1));
		row_last    = (row_q == ROW_W'(ROWS - 1));
		row_adv     = is_lf || (printable && col_last);
		will_scroll = row_adv && row_last;
		lin_cur     = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
		put_phys    = wrap_addr({1'b0, lin_cur} + {1'b0, base_q});
		rd_phys     = wrap_addr({1'b0, addr_q} + {1'b0, base_q});
		base_adv    = wrap_addr({1'b0, base_q} + (ADDR_W+1)'(COLUMNS));
		blank_word  = {(cmd.fill_rst ? ATTR_RESET : attr_q), CH_SPACE};
	end

	assign stat.mode        = mode_q;
	assign stat.will_scroll = will_scroll;
	assign stat.fill_last   = (sw_left_q == ADDR_W'(1));

	// Hold the attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_data;
		end
	end

	// Advance the cursor, ring offset and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			base_q    <= '0;
			sw_addr_q <= '0;
			sw_left_q <= ADDR_W'(CELL_COUNT);
			scr_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				scr_q <= 1'b0;
			end
			if (cmd.put) begin
				scr_q <= will_scroll;
				col_q <= (!printable || col_last) ? '0 : col_q + COL_W'(1);
				if (row_adv && !row_last) begin
					row_q <= row_q + ROW_W'(1);
				end
				if (will_scroll) begin
					base_q    <= base_adv;
					sw_addr_q <= base_q;
					sw_left_q <= ADDR_W'(COLUMNS);
				end
			end
			if (cmd.clear) begin
				row_q     <= '0;
				col_q     <= '0;
				base_q    <= '0;
				sw_addr_q <= '0;
				sw_left_q <= ADDR_W'(CELL_COUNT);
			end
			if (cmd.fill) begin
				sw_addr_q <= sw_addr_q + ADDR_W'(1);
				sw_left_q <= sw_left_q - ADDR_W'(1);
			end
		end
	end

	// Capture the request and the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			char_q <= in_char;
			addr_q <= in_addr;
		end
		if (cmd.read) begin
			rd_ok_q <= (addr_q < ADDR_W'(CELL_COUNT));
		end
		if (cmd.emit) begin
			pos_q     <= lin_cur;
			rdata_q   <= (mode_q == MODE_READ && rd_ok_q) ? rd_q : 16'h0000;
			scr_out_q <= scr_q;
		end
	end

	// Write and read the screen memory
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			mem[sw_addr_q] <= blank_word;
		end else if (cmd.put && printable) begin
			mem[put_phys] <= {attr_q, char_q};
		end
		if (cmd.read) begin
			rd_q <= mem[rd_phys];
		end
	end

	assign cursor_pos = pos_q;
	assign read_data  = rdata_q;
	assign scrolled   = scr_out_q;

endmodule

>>> src/tcw_ctrl.sv
// Controller: sequences each request and the memory sweeps, owns both handshakes.
module tcw_ctrl import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  tcw_stat_t stat,
	output tcw_cmd_t  cmd
);

	tcw_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.mode)
					MODE_PUT:   state_d = stat.will_scroll ? ST_FILL : ST_DONE;
					MODE_CLEAR: state_d = ST_FILL;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_FILL: begin
				if (stat.fill_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && s_tvalid;
		cmd.put      = (state_q == ST_EXEC) && (stat.mode == MODE_PUT);
		cmd.clear    = (state_q == ST_EXEC) && (stat.mode == MODE_CLEAR);
		cmd.read     = (state_q == ST_EXEC) && (stat.mode == MODE_READ);
		cmd.fill     = (state_q == ST_INIT) || (state_q == ST_FILL);
		cmd.fill_rst = (state_q == ST_INIT);
		cmd.emit     = (state_q == ST_DONE) && out_free;
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.emit || (out_valid_q && !m_tready);
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> src/text_console_writer.sv
// Top level of the character-cell text console writer.
//
// Requests enter on the s_ stream: tuser carries the mode (put, clear, read),
// tdata the character and the cell index. Each request yields one result on
// the m_ stream with the cursor position, the cell word for a read and a
// scroll flag. The attribute byte is written over the cfg channel, always ready.
// One request is processed at a time; a finished result waits in the output
// register while the next request is already taken.
// A read, an ignored mode or a put without scroll needs no sweep; a put that
// scrolls first blanks the new bottom row, and a clear first blanks every
// cell. These sweeps are paced by the single write port of the screen
// memory, one cell per cycle.
// Scrolling moves a row ring offset, so no cells are copied.
// After reset the block sweeps every cell to blank with attribute 0x07, with
// s_tready low; cfg writes are taken meanwhile.
// A stalled receiver holds the result; a new request then stops before its
// result until m_tready frees the output register.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], cell_addr[18:8], zero[23:19]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cursor_pos[10:0], read_data[26:11], zero[31:27]
	output logic        m_tuser,   // scrolled
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	tcw_cmd_t          cmd;
	tcw_stat_t         stat;
	logic [ADDR_W-1:0] cursor_pos;
	logic [15:0]       read_data;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcw_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (s_tuser),
		.in_char    (s_tdata[7:0]),
		.in_addr    (s_tdata[18:8]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.cursor_pos (cursor_pos),
		.read_data  (read_data),
		.scrolled   (m_tuser)
	);

	assign m_tdata = {5'b00000, read_data, cursor_pos};

	// One request in flight: no accept right after an accept
	`TCW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
		"request accepted while previous one still in progress")

	// Reported cursor always lies on the screen
	`TCW_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[10:0] < ADDR_W'(CELL_COUNT),
		"cursor position beyond the screen")

	// A scroll leaves the cursor on the last row
	`TCW_ASSERT_NOW(a_scroll_last_row, m_tvalid && m_tuser,
		m_tdata[10:0] >= ADDR_W'((ROWS - 1) * COLUMNS),
		"scroll reported with cursor above the last row")

endmodule
